// ===== design/mlads_pkg.sv =====
`default_nettype none

package mlads_pkg;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 4;

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_DUMP    = 2'd1,
        ACT_SPLICE  = 2'd2,
        ACT_INVALID = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== design/mlads_if.sv =====
`default_nettype none

interface mlads_in_if import mlads_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [INDEX_W-1:0]        list_index;
    logic [INDEX_W-1:0]        target_list;
    logic signed [VALUE_W-1:0] item_value;

    modport source (output valid, action, list_index, target_list, item_value, input ready);
    modport sink   (input valid, action, list_index, target_list, item_value, output ready);
endinterface

interface mlads_out_if import mlads_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic                      is_last;
    logic                      list_empty;
    logic [1:0]                status;

    modport source (output valid, out_value, is_last, list_empty, status, input ready);
    modport sink   (input valid, out_value, is_last, list_empty, status, output ready);
endinterface

`default_nettype wire

// ===== design/multi_list_append_dump_splice.sv =====
`default_nettype none

// Linked list queue manager. NUM_LISTS singly linked lists draw nodes from a shared pool
// of POOL_SIZE nodes that are handed out in order and never freed. Node values and links
// live in one RAM, list heads and tails in a second, and the nonempty flag of each list in
// flip-flops that reset clears, so the block takes input as soon as reset ends. One
// input beat is taken at a time. An invalid or out-of-range request goes straight to
// the result, as does a dump of an empty list once its list entry is read. An append
// writes the new node and the list entry, and on a nonempty list also gives the old tail
// node a read-modify-write. A splice stops after the list read when the source is empty
// or is spliced onto itself; else it rewrites the target's list entry and, when the target
// is not empty, also relinks the target's tail node. A dump of a nonempty list walks it,
// following one link per read of the node RAM. The result register lets the next beat
// enter while a result waits, and a dump pauses its walk while the result side stalls.
module multi_list_append_dump_splice
    import mlads_pkg::*;
#(
    parameter int NUM_LISTS = 16,
    parameter int POOL_SIZE = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mlads_in_if.sink    i_in,
    mlads_out_if.source o_out
);

    localparam int NODE_W     = $clog2(POOL_SIZE);
    localparam int CNT_W      = $clog2(POOL_SIZE + 1);
    localparam int LIST_DEPTH = (NUM_LISTS < (1 << INDEX_W)) ? NUM_LISTS : (1 << INDEX_W);
    localparam int LIST_W     = $clog2(LIST_DEPTH);
    localparam int NODE_RAM_W = VALUE_W + NODE_W;
    localparam int LIST_RAM_W = 2 * NODE_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LIST   = 7'b0000010,
        S_TAIL   = 7'b0000100,
        S_WALK   = 7'b0001000,
        S_DST    = 7'b0010000,
        S_SPTAIL = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    t_action               r_action, n_action;
    logic [LIST_W-1:0]     r_src, n_src;
    logic [LIST_W-1:0]     r_dst, n_dst;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic [NODE_W-1:0]     r_first, n_first;
    logic [NODE_W-1:0]     r_last, n_last;
    logic [NODE_W-1:0]     r_node, n_node;
    logic [NODE_W-1:0]     r_k, n_k;
    logic [CNT_W-1:0]      r_used, n_used;
    logic [LIST_DEPTH-1:0] r_nonempty, n_nonempty;
    t_status               r_status, n_status;
    logic                  r_empty, n_empty;

    logic                  r_ov;
    logic [VALUE_W-1:0]    r_oval;
    logic                  r_olast;
    logic                  r_oempty;
    t_status               r_ostatus;

    logic                  w_load;
    logic [VALUE_W-1:0]    w_lval;
    logic                  w_llast;
    logic                  w_lempty;
    t_status               w_lstat;
    logic                  w_slot;
    logic                  w_bad;
    logic                  w_end;
    logic [NODE_W-1:0]     w_new;

    logic                  list_we, list_re;
    logic [LIST_W-1:0]     list_waddr, list_raddr;
    logic [LIST_RAM_W-1:0] list_wdata, list_rdata;
    logic                  node_we, node_re;
    logic [NODE_W-1:0]     node_waddr, node_raddr;
    logic [NODE_RAM_W-1:0] node_wdata, node_rdata;

    logic [NODE_W-1:0]     l_first, l_last, l_link;
    logic [VALUE_W-1:0]    l_value;

    mlads_ram #(.WIDTH(LIST_RAM_W), .DEPTH(LIST_DEPTH)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_re    (list_re),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    mlads_ram #(.WIDTH(NODE_RAM_W), .DEPTH(POOL_SIZE)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    assign l_first = list_rdata[LIST_RAM_W-1:NODE_W];
    assign l_last  = list_rdata[NODE_W-1:0];
    assign l_link  = node_rdata[NODE_RAM_W-1:VALUE_W];
    assign l_value = node_rdata[VALUE_W-1:0];
    assign w_new   = r_used[NODE_W-1:0];
    assign w_slot  = !r_ov || o_out.ready;
    assign w_end   = (r_node == r_last) || (r_k == NODE_W'(POOL_SIZE - 1));

    assign w_bad = (t_action'(i_in.action) == ACT_INVALID)
                || (32'(i_in.list_index) >= NUM_LISTS)
                || ((t_action'(i_in.action) == ACT_SPLICE)
                    && (32'(i_in.target_list) >= NUM_LISTS));

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_action   = r_action;
        n_src      = r_src;
        n_dst      = r_dst;
        n_value    = r_value;
        n_first    = r_first;
        n_last     = r_last;
        n_node     = r_node;
        n_k        = r_k;
        n_used     = r_used;
        n_nonempty = r_nonempty;
        n_status   = r_status;
        n_empty    = r_empty;
        list_re    = 1'b0;
        list_raddr = r_src;
        list_we    = 1'b0;
        list_waddr = r_src;
        list_wdata = '0;
        node_re    = 1'b0;
        node_raddr = r_node;
        node_we    = 1'b0;
        node_waddr = w_new;
        node_wdata = '0;
        w_load     = 1'b0;
        w_lval     = '0;
        w_llast    = 1'b1;
        w_lempty   = 1'b0;
        w_lstat    = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_action   = t_action'(i_in.action);
                    n_src      = i_in.list_index[LIST_W-1:0];
                    n_dst      = i_in.target_list[LIST_W-1:0];
                    n_value    = i_in.item_value;
                    list_re    = 1'b1;
                    list_raddr = i_in.list_index[LIST_W-1:0];
                    n_empty    = 1'b0;
                    n_status   = ST_OK;
                    if (w_bad) begin
                        n_status = ST_INVALID;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_LIST;
                    end
                end
            end
            S_LIST: begin
                n_first = l_first;
                n_last  = l_last;
                case (r_action)
                    ACT_APPEND: begin
                        if (r_used == CNT_W'(POOL_SIZE)) begin
                            n_status = ST_FULL;
                            n_state  = S_RESP;
                        end else begin
                            node_we    = 1'b1;
                            node_waddr = w_new;
                            node_wdata = {NODE_W'(0), r_value};
                            list_we    = 1'b1;
                            list_waddr = r_src;
                            n_used     = r_used + CNT_W'(1);
                            n_node     = w_new;
                            if (r_nonempty[r_src]) begin
                                list_wdata = {l_first, w_new};
                                node_re    = 1'b1;
                                node_raddr = l_last;
                                n_state    = S_TAIL;
                            end else begin
                                list_wdata        = {w_new, w_new};
                                n_nonempty[r_src] = 1'b1;
                                n_state           = S_RESP;
                            end
                        end
                    end
                    ACT_DUMP: begin
                        if (!r_nonempty[r_src]) begin
                            n_empty = 1'b1;
                            n_state = S_RESP;
                        end else begin
                            node_re    = 1'b1;
                            node_raddr = l_first;
                            n_node     = l_first;
                            n_k        = '0;
                            n_state    = S_WALK;
                        end
                    end
                    ACT_SPLICE: begin
                        if (!r_nonempty[r_src]) begin
                            n_state = S_RESP;
                        end else if (r_src == r_dst) begin
                            n_nonempty[r_src] = 1'b0;
                            n_state           = S_RESP;
                        end else begin
                            list_re    = 1'b1;
                            list_raddr = r_dst;
                            n_state    = S_DST;
                        end
                    end
                    default: begin
                        n_status = ST_INVALID;
                        n_state  = S_RESP;
                    end
                endcase
            end
            S_TAIL: begin
                node_we    = 1'b1;
                node_waddr = r_last;
                node_wdata = {r_node, l_value};
                n_state    = S_RESP;
            end
            S_DST: begin
                list_we           = 1'b1;
                list_waddr        = r_dst;
                n_nonempty[r_src] = 1'b0;
                if (r_nonempty[r_dst]) begin
                    list_wdata = {l_first, r_last};
                    node_re    = 1'b1;
                    node_raddr = l_last;
                    n_node     = l_last;
                    n_state    = S_SPTAIL;
                end else begin
                    list_wdata        = {r_first, r_last};
                    n_nonempty[r_dst] = 1'b1;
                    n_state           = S_RESP;
                end
            end
            S_SPTAIL: begin
                node_we    = 1'b1;
                node_waddr = r_node;
                node_wdata = {r_first, l_value};
                n_state    = S_RESP;
            end
            S_WALK: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    w_lval  = l_value;
                    w_llast = w_end;
                    if (w_end) begin
                        n_state = S_IDLE;
                    end else begin
                        node_re    = 1'b1;
                        node_raddr = l_link;
                        n_node     = l_link;
                        n_k        = r_k + NODE_W'(1);
                    end
                end
            end
            S_RESP: begin
                if (w_slot) begin
                    w_load   = 1'b1;
                    w_lempty = r_empty;
                    w_lstat  = r_status;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_nonempty <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_nonempty <= n_nonempty;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_value  <= n_value;
        r_first  <= n_first;
        r_last   <= n_last;
        r_node   <= n_node;
        r_k      <= n_k;
        r_status <= n_status;
        r_empty  <= n_empty;
        if (w_load) begin
            r_oval    <= w_lval;
            r_olast   <= w_llast;
            r_oempty  <= w_lempty;
            r_ostatus <= w_lstat;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_value  = r_oval;
    assign o_out.is_last    = r_olast;
    assign o_out.list_empty = r_oempty;
    assign o_out.status     = r_ostatus;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("A second input beat was taken while an item was in progress.");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_used != $past(r_used))) |-> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("The node counter moved by other than one.");

    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(POOL_SIZE))
        else $error("The node counter ran past the pool size.");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> r_nonempty[r_src])
        else $error("A dump walk runs over a list marked empty.");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.list_empty) |-> (o_out.is_last && (o_out.out_value == '0)))
        else $error("An empty-list result is not a single zero beat.");

endmodule

`default_nettype wire

// ===== design/mlads_ram.sv =====
`default_nettype none

module mlads_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
